// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== hdl/tcce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared constants, codes, command/status structs and the tab stop table.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Default geometry
  localparam int unsigned COLS_DEF      = 80;
  localparam int unsigned ROWS_DEF      = 25;
  localparam int unsigned TAB_WIDTH_DEF = 8;

  // Fixed field widths
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned TGT_W     = 8;
  localparam int unsigned COL_OUT_W = 7;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned COLOR_W   = 8;

  // APB port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_COLOR = '0;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PUT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // Error bit positions
  localparam int unsigned ERR_COL_BIT = 0;
  localparam int unsigned ERR_ROW_BIT = 1;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
  localparam logic [CELL_W-1:0]  CELL_RESET  = 16'h0720;

  // Next tab stop for every possible column
  localparam int unsigned TAB_TBL_DEPTH = 128;
  typedef logic [7:0] tab_stop_t [TAB_TBL_DEPTH];

  function automatic tab_stop_t tab_stops(int unsigned tw);
    tab_stop_t   tbl;
    int unsigned stop;
    stop = tw;
    for (int unsigned c = 0; c < TAB_TBL_DEPTH; c++) begin
      if (c >= stop) begin
        stop = stop + tw;
      end
      tbl[c] = 8'(stop);
    end
    return tbl;
  endfunction

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_RESULT
  } tcce_state_e;

  typedef struct packed {
    logic capture;
    logic execute;
    logic clear_wr;
    logic blank_wr;
    logic cnt_rst;
    logic top_adv;
    logic result_load;
  } tcce_cmd_t;

  typedef struct packed {
    logic needs_scroll;
    logic sweep_last;
    logic line_last;
    logic out_free;
  } tcce_sts_t;

endpackage

// ===== hdl/tcce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor engine controller
// Sequences clear sweep, item execution, line scroll and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tcce_sts_t sts_i,
  output tcce_cmd_t cmd_o
);

  tcce_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.needs_scroll ? ST_SCROLL : ST_RESULT;
      end
      ST_SCROLL: begin
        if (sts_i.line_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        cmd_o.cnt_rst = 1'b1;
      end
      ST_SCROLL: begin
        cmd_o.blank_wr = 1'b1;
        cmd_o.top_adv  = sts_i.line_last;
      end
      ST_RESULT: begin
        cmd_o.result_load = sts_i.out_free;
      end
      default: ;
    endcase
  end

  `ASSERT_PROP(a_cmd_exclusive, clk_i, rst_ni,
    $onehot0({cmd_o.capture, cmd_o.execute, cmd_o.clear_wr, cmd_o.blank_wr, cmd_o.result_load}),
    "controller issued overlapping commands")
  `ASSERT_PROP(a_scroll_entry, clk_i, rst_ni,
    $rose(cmd_o.blank_wr) |-> $past(cmd_o.execute) && $past(sts_i.needs_scroll),
    "line clear started without a scroll request")
  `ASSERT_PROP(a_sweep_done, clk_i, rst_ni,
    cmd_o.clear_wr && sts_i.sweep_last |=> !cmd_o.clear_wr && !in_stall_o,
    "clear sweep did not hand over to idle")

endmodule

// ===== hdl/tcce_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor engine datapath
// Screen memory as a ring of lines, cursor, item and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_dpath
  import tcce_pkg::*;
#(
  parameter int unsigned COLS      = COLS_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcce_cmd_t            cmd_i,
  output tcce_sts_t            sts_o,
  input  logic [COLOR_W-1:0]   text_color_i,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [TGT_W-1:0]     target_col_i,
  input  logic [TGT_W-1:0]     target_row_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [COL_OUT_W-1:0] cursor_col_o,
  output logic [ROW_OUT_W-1:0] cursor_row_o,
  output logic [ERR_W-1:0]     error_bits_o,
  output logic [CELL_W-1:0]    cell_value_o,
  output logic                 scrolled_o
);

  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned DEPTH = COLS * ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam tab_stop_t TabStops = tab_stops(TAB_WIDTH);

  logic [CELL_W-1:0] mem_q [DEPTH];

  // Item registers
  logic [KIND_W-1:0] kind_q;
  logic [CHAR_W-1:0] char_q;
  logic [TGT_W-1:0]  tcol_q, trow_q;

  // Control state
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [RW-1:0] top_q;
  logic [AW-1:0] cnt_q;
  logic          out_valid_q;

  // Per-item results
  logic [ERR_W-1:0]  err_q, err_d;
  logic              scroll_q, scroll_d;
  logic              read_ok_q, read_ok_d;
  logic [CELL_W-1:0] rd_data_q;
  logic              put_wr;

  logic [COL_OUT_W-1:0] res_col_q;
  logic [ROW_OUT_W-1:0] res_row_q;
  logic [ERR_W-1:0]     res_err_q;
  logic [CELL_W-1:0]    res_cell_q;
  logic                 res_scroll_q;

  // Map a screen line onto the ring and return its base address
  function automatic logic [AW-1:0] line_base(logic [RW-1:0] line, logic [RW-1:0] top);
    logic [RW:0] sum;
    sum = {1'b0, line} + {1'b0, top};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return AW'(sum[RW-1:0]) * AW'(COLS);
  endfunction

  logic [AW-1:0]     cur_addr, rd_addr, blank_addr, wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              wr_en;

  assign cur_addr   = line_base(cur_row_q, top_q) + AW'(cur_col_q);
  assign rd_addr    = line_base(RW'(trow_q), top_q) + AW'(CW'(tcol_q));
  assign blank_addr = line_base('0, top_q) + cnt_q;

  // Item decode
  always_comb begin
    logic [7:0]  tab_next;
    logic [CW:0] col_inc;
    logic        lf;
    tab_next  = TabStops[7'(cur_col_q)];
    col_inc   = {1'b0, cur_col_q} + (CW+1)'(1);
    lf        = 1'b0;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    err_d     = '0;
    read_ok_d = 1'b0;
    put_wr    = 1'b0;
    case (kind_q)
      KIND_PUT: begin
        if (char_q == CH_NEWLINE) begin
          cur_col_d = '0;
          lf        = 1'b1;
        end else if (char_q == CH_RETURN) begin
          cur_col_d = '0;
        end else if (char_q == CH_TAB) begin
          if (tab_next >= 8'(COLS)) begin
            cur_col_d = '0;
            lf        = 1'b1;
          end else begin
            cur_col_d = CW'(tab_next);
          end
        end else begin
          put_wr = 1'b1;
          if (col_inc >= (CW+1)'(COLS)) begin
            cur_col_d = '0;
            lf        = 1'b1;
          end else begin
            cur_col_d = col_inc[CW-1:0];
          end
        end
      end
      KIND_MOVE, KIND_READ: begin
        err_d[ERR_COL_BIT] = tcol_q >= TGT_W'(COLS);
        err_d[ERR_ROW_BIT] = trow_q >= TGT_W'(ROWS);
        if (err_d == '0) begin
          if (kind_q == KIND_MOVE) begin
            cur_col_d = CW'(tcol_q);
            cur_row_d = RW'(trow_q);
          end else begin
            read_ok_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // Line feed past the last line keeps the cursor on it and scrolls
    scroll_d = lf && (cur_row_q == RW'(ROWS - 1));
    if (lf && !scroll_d) begin
      cur_row_d = cur_row_q + RW'(1);
    end
  end

  // Single write port: clear sweep, line blanking or character put
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = {text_color_i, char_q};
    if (cmd_i.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = CELL_RESET;
    end else if (cmd_i.blank_wr) begin
      wr_en   = 1'b1;
      wr_addr = blank_addr;
      wr_data = {text_color_i, BLANK_CHAR};
    end else if (cmd_i.execute && put_wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.execute) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
      tcol_q <= target_col_i;
      trow_q <= target_row_i;
    end
    if (cmd_i.execute) begin
      err_q     <= err_d;
      scroll_q  <= scroll_d;
      read_ok_q <= read_ok_d;
    end
    if (cmd_i.result_load) begin
      res_col_q    <= COL_OUT_W'(cur_col_q);
      res_row_q    <= ROW_OUT_W'(cur_row_q);
      res_err_q    <= err_q;
      res_cell_q   <= read_ok_q ? rd_data_q : '0;
      res_scroll_q <= scroll_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      top_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        cur_col_q <= cur_col_d;
        cur_row_q <= cur_row_d;
      end
      if (cmd_i.top_adv) begin
        top_q <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
      end
      if (cmd_i.cnt_rst) begin
        cnt_q <= '0;
      end else if (cmd_i.clear_wr || cmd_i.blank_wr) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (cmd_i.result_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.needs_scroll = scroll_d;
  assign sts_o.sweep_last   = cnt_q == AW'(DEPTH - 1);
  assign sts_o.line_last    = cnt_q == AW'(COLS - 1);
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = res_col_q;
  assign cursor_row_o = res_row_q;
  assign error_bits_o = res_err_q;
  assign cell_value_o = res_cell_q;
  assign scrolled_o   = res_scroll_q;

  `ASSERT_PROP(a_cursor_in_screen, clk_i, rst_ni,
    cur_col_q < CW'(COLS - 1) || cur_col_q == CW'(COLS - 1),
    "cursor column left the screen")
  `ASSERT_PROP(a_rows_in_ring, clk_i, rst_ni,
    (cur_row_q <= RW'(ROWS - 1)) && (top_q <= RW'(ROWS - 1)),
    "cursor line or ring top out of range")
  `ASSERT_PROP(a_top_moves_on_scroll, clk_i, rst_ni,
    !$stable(top_q) |-> $past(cmd_i.top_adv) && scroll_q,
    "ring top moved without a scroll")

endmodule

// ===== hdl/text_console_cursor_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character screen with cursor, tab stops, line wrap and scroll-up.
// ----------------------------------------------------------------------------
// Flow: an item is captured, then executed (cursor update, screen read); an
//   item that scrolls then blanks the new bottom line one cell a cycle through
//   the single write port of the screen memory. The result is registered once
//   the output is free, and only then is a new item taken.
// Reset: cursor to the top left, text colour 0x07; then a clearing pass
//   fills all COLS*ROWS cells with grey spaces, input stalled.
// ----------------------------------------------------------------------------

module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int unsigned COLS      = COLS_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // Item channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [TGT_W-1:0]     target_col_i,
  input  logic [TGT_W-1:0]     target_row_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [COL_OUT_W-1:0] cursor_col_o,
  output logic [ROW_OUT_W-1:0] cursor_row_o,
  output logic [ERR_W-1:0]     error_bits_o,
  output logic [CELL_W-1:0]    cell_value_o,
  output logic                 scrolled_o
);

  logic [COLOR_W-1:0] text_color_q;
  logic               color_sel;
  tcce_cmd_t          cmd;
  tcce_sts_t          sts;

  // Register file: a single attribute byte, written in the APB access phase
  assign pready    = 1'b1;
  assign color_sel = paddr[PADDR_W-1:2] == REG_TEXT_COLOR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= COLOR_RESET;
    end else if (psel && penable && pwrite && pready && color_sel) begin
      text_color_q <= pwdata[COLOR_W-1:0];
    end
  end

  // Read back the colour; unmapped addresses read as zero
  assign prdata = color_sel ? PDATA_W'(text_color_q) : '0;

  // Controller: clear sweep, then one item at a time
  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: screen ring, cursor and output register
  tcce_dpath #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .text_color_i (text_color_q),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .target_col_i (target_col_i),
    .target_row_i (target_row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .error_bits_o (error_bits_o),
    .cell_value_o (cell_value_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

// ===== tb/sv/tb_text_console_cursor_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Drives put, move, read and spare commands through the item channel in random
// bursts. It predicts the cursor, error bits, cell contents and scroll flag of
// every result beat from a local copy of the screen, and checks each beat as
// it leaves. The text colour is rewritten over APB between phases, once the
// engine has drained.
// ----------------------------------------------------------------------------

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int SCREEN_COLS = COLS_DEF;
  localparam int SCREEN_ROWS = ROWS_DEF;
  localparam int TAB_STEP    = TAB_WIDTH_DEF;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

  // Kind code that the engine decodes as no operation
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic [PADDR_W-1:0] COLOR_ADDR = PADDR_W'(4 * REG_TEXT_COLOR);

  // Cycles to hold after the last result: one scroll plus the pipeline
  localparam int DRAIN_CYCLES = SCREEN_COLS + 20;
  // Give up well beyond the slowest legal run (clear pass, every item
  // scrolling, every beat stalled at length)
  localparam longint TIMEOUT_NS = 64'd15_000_000;

  localparam int ITEMS_PER_PHASE = 400;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;
    logic [TGT_W-1:0]  target_col;
    logic [TGT_W-1:0]  target_row;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [ERR_W-1:0]     error_bits;
    logic [CELL_W-1:0]    cell_value;
    logic                 scrolled;
  } console_status_t;

  // Clock, reset and ports
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  console_cmd_t       cmd_drv = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [COL_OUT_W-1:0] cursor_col_o;
  logic [ROW_OUT_W-1:0] cursor_row_o;
  logic [ERR_W-1:0]     error_bits_o;
  logic [CELL_W-1:0]    cell_value_o;
  logic                 scrolled_o;

  // Commands waiting to be driven and status beats owed by the engine
  console_cmd_t    cmd_q[$];
  console_status_t status_due_q[$];
  int              n_issued = 0;
  int              n_retired = 0;
  int              fail_count = 0;

  // Predicted engine state
  logic [CELL_W-1:0]  screen [CELL_COUNT];
  int                 cur_col = 0;
  int                 cur_row = 0;
  logic [COLOR_W-1:0] pen_color = COLOR_RESET;

  // Sender burst shaping and receiver stall pattern
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  text_console_cursor_engine uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .kind_i       (cmd_drv.kind),
    .char_code_i  (cmd_drv.char_code),
    .target_col_i (cmd_drv.target_col),
    .target_row_i (cmd_drv.target_row),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .error_bits_o (error_bits_o),
    .cell_value_o (cell_value_o),
    .scrolled_o   (scrolled_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Step the cursor down a line; at the bottom, shift every line up one and
  // blank the new last line in the current colour.
  function automatic logic feed_line();
    cur_row++;
    if (cur_row < SCREEN_ROWS) begin
      return 1'b0;
    end
    for (int i = 0; i + SCREEN_COLS < CELL_COUNT; i++) begin
      screen[i] = screen[i + SCREEN_COLS];
    end
    for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++) begin
      screen[i] = {pen_color, BLANK_CHAR};
    end
    cur_row = SCREEN_ROWS - 1;
    return 1'b1;
  endfunction

  // Apply one accepted command to the predicted screen and work out the
  // status beat that it owes.
  function automatic console_status_t advance_console(console_cmd_t cmd);
    console_status_t st;
    int              stop;
    st = '0;
    case (cmd.kind)
      KIND_PUT: begin
        if (cmd.char_code == CH_NEWLINE) begin
          cur_col = 0;
          st.scrolled = feed_line();
        end else if (cmd.char_code == CH_RETURN) begin
          cur_col = 0;
        end else if (cmd.char_code == CH_TAB) begin
          stop = (cur_col / TAB_STEP + 1) * TAB_STEP;
          if (stop >= SCREEN_COLS) begin
            cur_col = 0;
            st.scrolled = feed_line();
          end else begin
            cur_col = stop;
          end
        end else begin
          screen[cur_row * SCREEN_COLS + cur_col] = {pen_color, cmd.char_code};
          cur_col++;
          if (cur_col >= SCREEN_COLS) begin
            cur_col = 0;
            st.scrolled = feed_line();
          end
        end
      end
      KIND_MOVE, KIND_READ: begin
        if (cmd.target_col >= SCREEN_COLS) begin
          st.error_bits[ERR_COL_BIT] = 1'b1;
        end
        if (cmd.target_row >= SCREEN_ROWS) begin
          st.error_bits[ERR_ROW_BIT] = 1'b1;
        end
        if (st.error_bits == '0) begin
          if (cmd.kind == KIND_MOVE) begin
            cur_col = int'(cmd.target_col);
            cur_row = int'(cmd.target_row);
          end else begin
            st.cell_value = screen[cmd.target_row * SCREEN_COLS + cmd.target_col];
          end
        end
      end
      default: begin
      end
    endcase
    st.cursor_col = COL_OUT_W'(cur_col);
    st.cursor_row = ROW_OUT_W'(cur_row);
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Item channel driver
  // --------------------------------------------------------------------------
  // Record the expectation on the accepting edge, then refill the slot from
  // the command queue unless a gap is running. Hold the payload while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      cmd_drv    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        status_due_q.push_back(advance_console(cmd_drv));
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cmd_drv <= cmd_q.pop_front();
          n_issued++;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // New burst; a third of them follow on with no gap at all
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result channel monitor and stall pattern
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  task automatic check_status();
    console_status_t want;
    if (status_due_q.size() == 0) begin
      fail_count++;
      $error("result beat with nothing outstanding");
    end else begin
      want = status_due_q.pop_front();
      n_retired++;
      compare_field("cursor_col", want.cursor_col, cursor_col_o);
      compare_field("cursor_row", want.cursor_row, cursor_row_o);
      compare_field("error_bits", want.error_bits, error_bits_o);
      compare_field("cell_value", want.cell_value, cell_value_o);
      compare_field("scrolled", want.scrolled, scrolled_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      stall_cnt  <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        check_status();
      end
      // Switch stall style at random intervals: none, light, heavy, periodic
      if (stall_cnt == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_cnt  <= $urandom_range(16, 96);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_cnt % 8) >= 4);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_cmd(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                    logic [TGT_W-1:0] col, logic [TGT_W-1:0] row);
    console_cmd_t c;
    c.kind       = kind;
    c.char_code  = ch;
    c.target_col = col;
    c.target_row = row;
    cmd_q.push_back(c);
  endfunction

  // Mostly writing traffic with in-range moves and reads; some out-of-range
  // coordinates and the spare kind as noise. Unused fields carry random bits.
  function automatic void queue_random_cmd();
    int                pick;
    int                sub;
    logic [CHAR_W-1:0] ch;
    logic [TGT_W-1:0]  col;
    logic [TGT_W-1:0]  row;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom_range(0, 255));
    col  = TGT_W'($urandom_range(0, 255));
    row  = TGT_W'($urandom_range(0, 255));
    if (pick < 55) begin
      if (sub < 68) begin
        ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
      end else if (sub < 80) begin
        ch = CH_NEWLINE;
      end else if (sub < 85) begin
        ch = CH_RETURN;
      end else if (sub < 93) begin
        ch = CH_TAB;
      end
      queue_cmd(KIND_PUT, ch, col, row);
    end else if (pick < 95) begin
      if (sub < 15) begin
        // Land near the bottom right so that wraps and scrolls come soon
        col = TGT_W'($urandom_range(SCREEN_COLS - 10, SCREEN_COLS - 1));
        row = TGT_W'(SCREEN_ROWS - 1);
      end else if (sub < 85) begin
        col = TGT_W'($urandom_range(0, SCREEN_COLS - 1));
        row = TGT_W'($urandom_range(0, SCREEN_ROWS - 1));
      end
      queue_cmd((pick < 75) ? KIND_MOVE : KIND_READ, ch, col, row);
    end else begin
      queue_cmd(KIND_SPARE, ch, col, row);
    end
  endfunction

  // Block until every queued command has been driven and answered
  task automatic wait_drained();
    while (cmd_q.size() != 0 || n_issued != n_retired) begin
      @(posedge clk_i);
    end
  endtask

  // Write the text colour over APB and read it straight back
  task automatic set_text_color(logic [COLOR_W-1:0] color);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COLOR_ADDR;
    pwdata  <= PDATA_W'(color);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    pen_color = color;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    compare_field("text_color", PDATA_W'(color), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [COLOR_W-1:0] palette [4];
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen[i] = CELL_RESET;
    end
    palette[0] = 8'h00;
    palette[1] = 8'hFF;
    palette[2] = COLOR_W'($urandom_range(1, 254));
    palette[3] = 8'h1E;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Let the clearing pass finish before touching the register
    do begin
      @(posedge clk_i);
    end while (in_stall_o);

    // Directed opening in the reset colour: fresh cells, both error bits,
    // wrap at the right edge, tabs, return, scroll at the bottom, spare kind.
    queue_cmd(KIND_READ, 8'h00, 8'd0, 8'd0);
    queue_cmd(KIND_READ, 8'hFF, TGT_W'(SCREEN_COLS - 1), TGT_W'(SCREEN_ROWS - 1));
    queue_cmd(KIND_READ, 8'h00, TGT_W'(SCREEN_COLS), 8'd0);
    queue_cmd(KIND_READ, 8'h00, 8'd0, TGT_W'(SCREEN_ROWS));
    queue_cmd(KIND_READ, 8'h00, 8'hFF, 8'hFF);
    queue_cmd(KIND_MOVE, 8'h00, TGT_W'(SCREEN_COLS), 8'd3);
    queue_cmd(KIND_MOVE, 8'h00, 8'd3, TGT_W'(SCREEN_ROWS));
    queue_cmd(KIND_MOVE, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(KIND_MOVE, 8'h00, TGT_W'(SCREEN_COLS - 1), 8'd0);
    queue_cmd(KIND_PUT, 8'h41, 8'h00, 8'h00);
    queue_cmd(KIND_READ, 8'h00, TGT_W'(SCREEN_COLS - 1), 8'd0);
    queue_cmd(KIND_PUT, 8'h00, 8'hFF, 8'hFF);
    queue_cmd(KIND_PUT, 8'hFF, 8'h00, 8'h00);
    queue_cmd(KIND_PUT, CH_TAB, 8'h00, 8'h00);
    queue_cmd(KIND_PUT, CH_RETURN, 8'h00, 8'h00);
    queue_cmd(KIND_MOVE, 8'h00, TGT_W'(SCREEN_COLS - TAB_STEP), 8'd5);
    queue_cmd(KIND_PUT, CH_TAB, 8'h00, 8'h00);
    queue_cmd(KIND_MOVE, 8'h00, TGT_W'(SCREEN_COLS - 1), TGT_W'(SCREEN_ROWS - 1));
    queue_cmd(KIND_PUT, 8'h5A, 8'h00, 8'h00);
    queue_cmd(KIND_READ, 8'h00, TGT_W'(SCREEN_COLS - 1), TGT_W'(SCREEN_ROWS - 2));
    queue_cmd(KIND_READ, 8'h00, 8'd0, TGT_W'(SCREEN_ROWS - 1));
    queue_cmd(KIND_PUT, CH_NEWLINE, 8'h00, 8'h00);
    queue_cmd(KIND_SPARE, 8'hA5, 8'h5A, 8'hC3);
    queue_cmd(KIND_READ, 8'h00, 8'd1, 8'd1);
    wait_drained();

    // Random phases, each under its own colour and started from an idle engine
    foreach (palette[p]) begin
      set_text_color(palette[p]);
      repeat (ITEMS_PER_PHASE) queue_random_cmd();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
